/* rtl/scz_pkg.sv */
// ----------------------------------------------------------------------------
// scz_pkg: shared definitions for the centred zoom scaler
// Sizes, register map, reset values and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package scz_pkg;

  // Frame store and fixed-point sizes.
  localparam int FRAME_WORDS     = 32768;
  localparam int FRAME_AW        = $clog2(FRAME_WORDS);
  localparam int SCALE_FRAC_BITS = 16;
  localparam int INV_W           = 8 + SCALE_FRAC_BITS;
  // Divider: for the inverse scales the numerator holds source*100 shifted by the fraction bits.
  localparam int DIV_NW          = 16 + SCALE_FRAC_BITS;
  localparam int DIV_DW          = 19;
  localparam int DIV_CW          = $clog2(DIV_NW);

  // Zoom of one hundred percent.
  localparam logic [9:0] ZOOM_UNIT = 10'd100;

  // Register indexes.
  localparam logic [2:0] REG_FULL_SCREEN = 3'd0;
  localparam logic [2:0] REG_ZOOM        = 3'd1;
  localparam logic [2:0] REG_SRC_W       = 3'd2;
  localparam logic [2:0] REG_SRC_H       = 3'd3;
  localparam logic [2:0] REG_PITCH       = 3'd4;
  localparam logic [2:0] REG_SCR_W       = 3'd5;
  localparam logic [2:0] REG_SCR_H       = 3'd6;

  // Reset values of the registers.
  localparam logic       RST_FULL_SCREEN = 1'b1;
  localparam logic [9:0] RST_ZOOM        = 10'd100;
  localparam logic [8:0] RST_SRC_W       = 9'd160;
  localparam logic [8:0] RST_SRC_H       = 9'd144;
  localparam logic [8:0] RST_PITCH       = 9'd160;
  localparam logic [8:0] RST_SCR_W       = 9'd240;
  localparam logic [8:0] RST_SCR_H       = 9'd135;

  // Divider operand selection.
  localparam logic [1:0] DIV_DIM  = 2'd0;
  localparam logic [1:0] DIV_INVX = 2'd1;
  localparam logic [1:0] DIV_INVY = 2'd2;

  typedef struct packed {
    logic       full_screen;
    logic [9:0] zoom;
    logic [8:0] src_w;
    logic [8:0] src_h;
    logic [8:0] pitch;
    logic [8:0] scr_w;
    logic [8:0] scr_h;
  } cfg_t;

  typedef struct packed {
    logic       req_capture;
    logic       mem_write;
    logic       map_mul;
    logic       map_add;
    logic       addr_calc;
    logic       mem_read;
    logic       out_load;
    logic       geo_latch;
    logic       full_load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       dim_load;
    logic       ofs_load;
    logic       invx_load;
    logic       invy_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic geo_zero;
    logic full_screen;
    logic req_ok;
    logic div_done;
  } dp_stat_t;

endpackage

/* rtl/centered_zoom_nearest_scaler_top.sv */
// ----------------------------------------------------------------------------
// Centred zoom nearest-neighbour scaler
// Source frame store with a nearest-pixel lookup for a scaled, centred window.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel (in_valid/in_stall) takes one word per item. With
//  in_action low the word writes in_store_pixel into the frame store, one
//  write per cycle while in_stall is low. With in_action high it requests
//  the window pixel (in_window_x, in_window_y); requests inside the window
//  return one word on the output channel (out_valid/out_stall), those
//  outside return nothing. A request holds the input stalled through its
//  steps (multiply, add and clamp, address multiply, store read, output
//  load) and its word is registered at the output load; a new request is
//  taken only once the last has left these steps.
//  The transform is recomputed after reset and after every register write
//  on the APB port, unless a size is zero, through the shared serial
//  divider (one quotient bit a cycle); the input is stalled meanwhile.
//  While the receiver stalls, the output word holds; a finished request then
//  waits in the last step until the output register frees.
//  Reset restores the register defaults; the frame store keeps its content.
// ----------------------------------------------------------------------------
module centered_zoom_nearest_scaler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [14:0] in_store_address,
  input  logic [15:0] in_store_pixel,
  input  logic [8:0]  in_window_x,
  input  logic [8:0]  in_window_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel,
  output logic [8:0]  out_screen_x,
  output logic [8:0]  out_screen_y,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scz_pkg::cfg_t      cfg;
  scz_pkg::ctl_cmd_t  cmd;
  scz_pkg::dp_stat_t  stat;
  logic               cfg_wr;

  // Register bank.
  scz_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // Controller.
  scz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  scz_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_store_address (in_store_address),
    .in_store_pixel   (in_store_pixel),
    .in_window_x      (in_window_x),
    .in_window_y      (in_window_y),
    .out_pixel        (out_pixel),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_frame_last   (out_frame_last)
  );

`ifndef ASSERT_OFF
  // An accepted request occupies the block for the next cycle.
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action |=> in_stall)
    else $error("input not stalled after a request");

  // A register write triggers a recomputation that stalls the input.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_stall)
    else $error("input not stalled after a register write");

  // A new output word only comes out of request processing.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word without a request in flight");
`endif

endmodule

/* rtl/scz_regs.sv */
// ----------------------------------------------------------------------------
// scz_regs: configuration register bank
// APB-style slave holding the seven scaler registers; flags every write.
// ----------------------------------------------------------------------------
module scz_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output scz_pkg::cfg_t  cfg,
  output logic           cfg_wr
);

  scz_pkg::cfg_t cfg_r;
  logic [2:0]    idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_screen <= scz_pkg::RST_FULL_SCREEN;
      cfg_r.zoom        <= scz_pkg::RST_ZOOM;
      cfg_r.src_w       <= scz_pkg::RST_SRC_W;
      cfg_r.src_h       <= scz_pkg::RST_SRC_H;
      cfg_r.pitch       <= scz_pkg::RST_PITCH;
      cfg_r.scr_w       <= scz_pkg::RST_SCR_W;
      cfg_r.scr_h       <= scz_pkg::RST_SCR_H;
    end else if (cfg_wr) begin
      unique case (idx)
        scz_pkg::REG_FULL_SCREEN: cfg_r.full_screen <= pwdata[0];
        scz_pkg::REG_ZOOM:        cfg_r.zoom        <= pwdata[9:0];
        scz_pkg::REG_SRC_W:       cfg_r.src_w       <= pwdata[8:0];
        scz_pkg::REG_SRC_H:       cfg_r.src_h       <= pwdata[8:0];
        scz_pkg::REG_PITCH:       cfg_r.pitch       <= pwdata[8:0];
        scz_pkg::REG_SCR_W:       cfg_r.scr_w       <= pwdata[8:0];
        scz_pkg::REG_SCR_H:       cfg_r.scr_h       <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      scz_pkg::REG_FULL_SCREEN: prdata = {31'd0, cfg_r.full_screen};
      scz_pkg::REG_ZOOM:        prdata = {22'd0, cfg_r.zoom};
      scz_pkg::REG_SRC_W:       prdata = {23'd0, cfg_r.src_w};
      scz_pkg::REG_SRC_H:       prdata = {23'd0, cfg_r.src_h};
      scz_pkg::REG_PITCH:       prdata = {23'd0, cfg_r.pitch};
      scz_pkg::REG_SCR_W:       prdata = {23'd0, cfg_r.scr_w};
      scz_pkg::REG_SCR_H:       prdata = {23'd0, cfg_r.scr_h};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/scz_div.sv */
// ----------------------------------------------------------------------------
// scz_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; pulses done when finished.
// ----------------------------------------------------------------------------
module scz_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scz_pkg::DIV_NW-1:0]  numer,
  input  logic [scz_pkg::DIV_DW-1:0]  denom,
  output logic                        done,
  output logic [scz_pkg::DIV_NW-1:0]  quot
);

  logic                        busy_r;
  logic                        done_r;
  logic [scz_pkg::DIV_CW-1:0]  cnt_r;
  logic [scz_pkg::DIV_NW-1:0]  num_r;
  logic [scz_pkg::DIV_DW-1:0]  den_r;
  logic [scz_pkg::DIV_DW-1:0]  rem_r;
  logic [scz_pkg::DIV_DW:0]    rem_sh;
  logic                        fits;

  assign rem_sh = {rem_r, num_r[scz_pkg::DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign done   = done_r;
  assign quot   = num_r;

  // Sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == scz_pkg::DIV_CW'(scz_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= scz_pkg::DIV_DW'(rem_sh - {1'b0, den_r});
      end else begin
        rem_r <= rem_sh[scz_pkg::DIV_DW-1:0];
      end
      num_r <= {num_r[scz_pkg::DIV_NW-2:0], fits};
    end
  end

endmodule

/* rtl/scz_dp.sv */
// ----------------------------------------------------------------------------
// scz_dp: scaler datapath
// Frame store, transform registers, coordinate mapping stages and result word.
// ----------------------------------------------------------------------------
module scz_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scz_pkg::cfg_t        cfg,
  input  scz_pkg::ctl_cmd_t    cmd,
  output scz_pkg::dp_stat_t    stat,
  input  logic [14:0]          in_store_address,
  input  logic [15:0]          in_store_pixel,
  input  logic [8:0]           in_window_x,
  input  logic [8:0]           in_window_y,
  output logic [15:0]          out_pixel,
  output logic [8:0]           out_screen_x,
  output logic [8:0]           out_screen_y,
  output logic                 out_frame_last
);

  localparam int F   = scz_pkg::SCALE_FRAC_BITS;
  localparam int PW  = 11 + scz_pkg::INV_W + 1;
  localparam int TW  = PW + 1;
  localparam int AW  = scz_pkg::FRAME_AW;

  // Transform state.
  logic [8:0]                 ww_r, wh_r, ox_r, oy_r;
  logic [scz_pkg::INV_W-1:0]  invx_r, invy_r;
  logic                       aspect_h_r;

  // Request state.
  logic [8:0]        wx_r, wy_r, sx_r, sy_r;
  logic              last_r;
  logic signed [PW-1:0] prodx_r, prody_r;
  logic [AW-1:0]     addr_r;
  logic [15:0]       rd_r;
  logic [15:0]       mem [scz_pkg::FRAME_WORDS];

  // Divider.
  logic                        div_done;
  logic [scz_pkg::DIV_NW-1:0]  div_q, div_n;
  logic [scz_pkg::DIV_DW-1:0]  div_d;
  logic [9:0]                  zoom_eff;
  logic [scz_pkg::INV_W-1:0]   inv_sat;
  logic [8:0]                  dim_q;

  // Mapping helpers.
  logic signed [10:0] dx, dy;
  logic signed [TW-1:0] tx, ty;
  logic [8:0]  sx_nxt, sy_nxt;
  logic [31:0] wr_addr_w;
  logic [18:0] rd_addr_w;

  assign zoom_eff = (cfg.zoom == 10'd0) ? scz_pkg::ZOOM_UNIT : cfg.zoom;

  // Status to the controller.
  assign stat.geo_zero    = (cfg.src_w == 9'd0) || (cfg.src_h == 9'd0) ||
                            (cfg.scr_w == 9'd0) || (cfg.scr_h == 9'd0);
  assign stat.full_screen = cfg.full_screen;
  assign stat.req_ok      = (cfg.src_w != 9'd0) && (cfg.src_h != 9'd0) &&
                            (cfg.pitch != 9'd0) && (wx_r < ww_r) && (wy_r < wh_r);
  assign stat.div_done    = div_done;

  // Divider operand selection.
  always_comb begin
    unique case (cmd.div_sel)
      scz_pkg::DIV_DIM: begin
        div_n = aspect_h_r ? scz_pkg::DIV_NW'(18'(cfg.src_h) * 18'(cfg.scr_w))
                           : scz_pkg::DIV_NW'(18'(cfg.src_w) * 18'(cfg.scr_h));
        div_d = aspect_h_r ? scz_pkg::DIV_DW'(cfg.src_w)
                           : scz_pkg::DIV_DW'(cfg.src_h);
      end
      scz_pkg::DIV_INVX: begin
        div_n = scz_pkg::DIV_NW'(16'(cfg.src_w) * 16'(scz_pkg::ZOOM_UNIT)) << F;
        div_d = scz_pkg::DIV_DW'(19'(ww_r) * 19'(zoom_eff));
      end
      scz_pkg::DIV_INVY: begin
        div_n = scz_pkg::DIV_NW'(16'(cfg.src_h) * 16'(scz_pkg::ZOOM_UNIT)) << F;
        div_d = scz_pkg::DIV_DW'(19'(wh_r) * 19'(zoom_eff));
      end
      default: begin
        div_n = '0;
        div_d = scz_pkg::DIV_DW'(1);
      end
    endcase
  end

  scz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (div_n),
    .denom (div_d),
    .done  (div_done),
    .quot  (div_q)
  );

  // Saturated inverse scale and clamped window size from the quotient.
  assign inv_sat = (|div_q[scz_pkg::DIV_NW-1:scz_pkg::INV_W]) ? '1
                                                             : div_q[scz_pkg::INV_W-1:0];
  assign dim_q   = (div_q == '0) ? 9'd1 : div_q[8:0];

  // Transform registers.
  always_ff @(posedge clk) begin
    if (cmd.geo_latch) begin
      aspect_h_r <= (18'(cfg.scr_w) * 18'(cfg.src_h)) <= (18'(cfg.scr_h) * 18'(cfg.src_w));
    end
    if (cmd.full_load) begin
      ww_r <= cfg.scr_w;
      wh_r <= cfg.scr_h;
      ox_r <= 9'd0;
      oy_r <= 9'd0;
    end
    if (cmd.dim_load) begin
      if (aspect_h_r) begin
        ww_r <= cfg.scr_w;
        wh_r <= dim_q;
      end else begin
        wh_r <= cfg.scr_h;
        ww_r <= dim_q;
      end
    end
    if (cmd.ofs_load) begin
      ox_r <= (ww_r < cfg.scr_w) ? 9'((cfg.scr_w - ww_r) >> 1) : 9'd0;
      oy_r <= (wh_r < cfg.scr_h) ? 9'((cfg.scr_h - wh_r) >> 1) : 9'd0;
    end
    if (cmd.invx_load) invx_r <= inv_sat;
    if (cmd.invy_load) invy_r <= inv_sat;
  end

  // Distance from the window centre in half pixels.
  assign dx = $signed({1'b0, wx_r, 1'b0}) - $signed({2'b00, ww_r - 9'd1});
  assign dy = $signed({1'b0, wy_r, 1'b0}) - $signed({2'b00, wh_r - 9'd1});

  // Source position in units of half a fixed-point step.
  assign tx = $signed({{(TW - 9 - F){1'b0}}, cfg.src_w, {F{1'b0}}}) + TW'(prodx_r);
  assign ty = $signed({{(TW - 9 - F){1'b0}}, cfg.src_h, {F{1'b0}}}) + TW'(prody_r);

  // Truncate, floor at zero, clamp to the last column or row.
  always_comb begin
    if (tx[TW-1]) begin
      sx_nxt = 9'd0;
    end else if (tx[TW-2:F+1] >= (TW-F-2)'(cfg.src_w)) begin
      sx_nxt = cfg.src_w - 9'd1;
    end else begin
      sx_nxt = tx[F+9:F+1];
    end
    if (ty[TW-1]) begin
      sy_nxt = 9'd0;
    end else if (ty[TW-2:F+1] >= (TW-F-2)'(cfg.src_h)) begin
      sy_nxt = cfg.src_h - 9'd1;
    end else begin
      sy_nxt = ty[F+9:F+1];
    end
  end

  assign rd_addr_w = 19'(18'(sy_r) * 18'(cfg.pitch)) + 19'(sx_r);
  assign wr_addr_w = 32'(in_store_address);

  // Request pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.req_capture) begin
      wx_r <= in_window_x;
      wy_r <= in_window_y;
    end
    if (cmd.map_mul) begin
      prodx_r <= dx * $signed({1'b0, invx_r});
      prody_r <= dy * $signed({1'b0, invy_r});
      last_r  <= (wx_r == ww_r - 9'd1) && (wy_r == wh_r - 9'd1);
    end
    if (cmd.map_add) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (cmd.addr_calc) begin
      addr_r <= rd_addr_w[AW-1:0];
    end
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[wr_addr_w[AW-1:0]] <= in_store_pixel;
    end
    if (cmd.mem_read) begin
      rd_r <= mem[addr_r];
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel      <= rd_r;
      out_screen_x   <= wx_r + ox_r;
      out_screen_y   <= wy_r + oy_r;
      out_frame_last <= last_r;
    end
  end

endmodule

/* rtl/scz_ctrl.sv */
// ----------------------------------------------------------------------------
// scz_ctrl: scaler controller
// Sequences transform recomputation and pixel requests; owns the handshakes.
// ----------------------------------------------------------------------------
module scz_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  scz_pkg::dp_stat_t   stat,
  output scz_pkg::ctl_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_GEO       = 4'd1;
  localparam logic [3:0] S_DIM       = 4'd2;
  localparam logic [3:0] S_DIM_WAIT  = 4'd3;
  localparam logic [3:0] S_OFS       = 4'd4;
  localparam logic [3:0] S_INVX      = 4'd5;
  localparam logic [3:0] S_INVX_WAIT = 4'd6;
  localparam logic [3:0] S_INVY      = 4'd7;
  localparam logic [3:0] S_INVY_WAIT = 4'd8;
  localparam logic [3:0] S_MAP_MUL   = 4'd9;
  localparam logic [3:0] S_MAP_ADD   = 4'd10;
  localparam logic [3:0] S_ADDR      = 4'd11;
  localparam logic [3:0] S_READ      = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  localparam logic ACT_WRITE = 1'b0;

  logic [3:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_stall  = !((state_r == S_IDLE) && !pend_r);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r || cfg_wr;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          pend_nxt  = cfg_wr;
          state_nxt = S_GEO;
        end else if (accept) begin
          if (in_action == ACT_WRITE) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.req_capture = 1'b1;
            state_nxt       = S_MAP_MUL;
          end
        end
      end
      S_GEO: begin
        if (stat.geo_zero) begin
          state_nxt = S_IDLE;
        end else if (stat.full_screen) begin
          cmd.full_load = 1'b1;
          state_nxt     = S_INVX;
        end else begin
          cmd.geo_latch = 1'b1;
          state_nxt     = S_DIM;
        end
      end
      S_DIM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scz_pkg::DIV_DIM;
        state_nxt     = S_DIM_WAIT;
      end
      S_DIM_WAIT: begin
        if (stat.div_done) begin
          cmd.dim_load = 1'b1;
          state_nxt    = S_OFS;
        end
      end
      S_OFS: begin
        cmd.ofs_load = 1'b1;
        state_nxt    = S_INVX;
      end
      S_INVX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scz_pkg::DIV_INVX;
        state_nxt     = S_INVX_WAIT;
      end
      S_INVX_WAIT: begin
        if (stat.div_done) begin
          cmd.invx_load = 1'b1;
          state_nxt     = S_INVY;
        end
      end
      S_INVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = scz_pkg::DIV_INVY;
        state_nxt     = S_INVY_WAIT;
      end
      S_INVY_WAIT: begin
        if (stat.div_done) begin
          cmd.invy_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MAP_MUL: begin
        if (stat.req_ok) begin
          cmd.map_mul = 1'b1;
          state_nxt   = S_MAP_ADD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAP_ADD: begin
        cmd.map_add = 1'b1;
        state_nxt   = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Reset starts a transform computation from the reset registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_GEO;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
